### design/assert_macros.svh
// Assertion macros shared by the weighted MAD column scaler modules.
// Include guard keeps repeated inclusion harmless.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication outside reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

### design/wmcs_pkg.sv
// Package for the weighted MAD column scaler: sizes, constants, command and status structs.
// Used by the RAM-free controller, datapath and top level.
package wmcs_pkg;
  localparam int MaxRows = 64;
  localparam int AddrW   = $clog2(MaxRows);
  localparam int CntW    = AddrW + 1;
  localparam logic [31:0] OneQ16 = 32'h0001_0000;

  typedef struct packed {
    logic load;      // store and accumulate input word
    logic div_start; // start a divider run
    logic div_scale; // 1: scale divide, 0: mean divide
    logic dev_acc;   // accumulate deviation of read sample
    logic emit;      // form scaled word of read sample
    logic clr;       // clear column state
    logic [AddrW-1:0] rd_addr;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic zero_w;
  } sts_t;
endpackage

### design/weighted_mad_column_scaler.sv
// Weighted MAD column scaler: loads a column of n words at one per cycle, then
// runs a mean divide, a deviation pass, a scale divide and an emit pass that
// reads one word at a time. A zero weight sum skips the divides and the
// deviation pass; otherwise the shared bit-serial divider sets most of the
// time to the first result word.
// Synchronous active-low reset clears control and sums.
module weighted_mad_column_scaler import wmcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_sample_value,
  input  logic [15:0] in_sample_weight,
  input  logic        in_column_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_scaled_value,
  output logic [31:0] out_column_mean,
  output logic [31:0] out_column_scale,
  output logic        out_zero_weight_error,
  output logic        out_last_of_column
);
  cmd_t cmd;
  sts_t sts;
  logic [AddrW-1:0] wr_addr;

  wmcs_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_end(in_column_end), .sts(sts), .cmd(cmd), .wr_addr(wr_addr),
    .out_valid(out_valid), .out_stall(out_stall), .out_last(out_last_of_column));

  wmcs_dp u_dp (.clk(clk), .rst_n(rst_n), .cmd(cmd), .wr_addr(wr_addr),
    .in_value(in_sample_value), .in_weight(in_sample_weight), .sts(sts),
    .res_value(out_scaled_value), .res_mean(out_column_mean),
    .res_scale(out_column_scale), .res_err(out_zero_weight_error));
endmodule

### design/wmcs_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module wmcs_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### design/wmcs_div.sv
// Unsigned restoring divider, one quotient bit per cycle, 96/64 bits.
// Depends on nothing but its ports.
module wmcs_div (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [95:0]  num,
  input  logic [63:0]  den,
  output logic         busy,
  output logic [95:0]  quo
);
  logic [6:0]  cnt_r, cnt_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [95:0] q_r, q_nxt;
  logic [63:0] den_r;
  logic [64:0] trial;

  // shift one bit per cycle
  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    trial = {rem_r[63:0], q_r[95]} - {1'b0, den_r};
    if (start) begin
      cnt_nxt = 7'd96;
      rem_nxt = '0;
      q_nxt = num;
    end else if (cnt_r != 7'd0) begin
      cnt_nxt = cnt_r - 7'd1;
      if (!trial[64]) begin
        rem_nxt = trial;
        q_nxt = {q_r[94:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[63:0], q_r[95]};
        q_nxt = {q_r[94:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    if (start) den_r <= den;
  end

  assign busy = (cnt_r != 7'd0);
  assign quo = q_r;
endmodule

### design/wmcs_dp.sv
// Datapath: sample stores, sums, divider, deviation and scaling pipes.
// Depends on wmcs_pkg, wmcs_ram, wmcs_div and assert_macros.svh.
`include "assert_macros.svh"
module wmcs_dp import wmcs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic [AddrW-1:0]  wr_addr,
  input  logic [31:0]       in_value,
  input  logic [15:0]       in_weight,
  output sts_t              sts,
  output logic [31:0]       res_value,
  output logic [31:0]       res_mean,
  output logic [31:0]       res_scale,
  output logic              res_err
);
  logic [31:0] val_rd;
  logic [15:0] wt_rd;
  logic signed [63:0] wsum_r;
  logic [22:0] wtot_r;
  logic signed [31:0] mean_r;
  logic [31:0] scale_r;
  logic [63:0] dev_r;
  logic [95:0] num;
  logic [63:0] den;
  logic [95:0] quo;
  logic div_busy;
  logic busy_d_r;
  logic signed [63:0] wsum_abs;
  logic mean_neg;
  logic signed [33:0] d;
  logic [33:0] a;
  logic [49:0] aw;
  logic [49:0] hi_p;
  logic [47:0] lo_p;
  logic [49:0] p;
  logic neg;

  wmcs_ram #(.Width(32), .Depth(MaxRows)) u_val (
    .clk(clk), .we(cmd.load), .waddr(wr_addr), .wdata(in_value),
    .raddr(cmd.rd_addr), .rdata(val_rd));
  wmcs_ram #(.Width(16), .Depth(MaxRows)) u_wt (
    .clk(clk), .we(cmd.load), .waddr(wr_addr), .wdata(in_weight),
    .raddr(cmd.rd_addr), .rdata(wt_rd));

  // divider operands: magnitude of weighted sum, or weight total << 32
  assign mean_neg = wsum_r[63];
  assign wsum_abs = mean_neg ? -wsum_r : wsum_r;
  assign num = cmd.div_scale ? {41'd0, wtot_r, 32'd0} : {32'd0, wsum_abs};
  assign den = cmd.div_scale ? dev_r : {41'd0, wtot_r};

  wmcs_div u_div (.clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(num),
    .den(den), .busy(div_busy), .quo(quo));

  assign sts.div_busy = div_busy;
  assign sts.zero_w = (wtot_r == 23'd0);

  // centered magnitude of the read sample
  assign d = 34'(signed'(val_rd)) - 34'(mean_r);
  assign neg = d[33];
  assign a = neg ? 34'(-d) : d;
  assign aw = 50'(a) * 50'(wt_rd);
  assign hi_p = 50'(a[33:16]) * 50'(scale_r);
  assign lo_p = 48'(a[15:0]) * 48'(scale_r);
  assign p = hi_p + 50'(lo_p[47:16]);

  // remember divider busy to catch its finishing cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_d_r <= 1'b0;
    end else begin
      busy_d_r <= div_busy;
    end
  end

  // hold sums and results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsum_r <= '0;
      wtot_r <= '0;
      dev_r <= '0;
      mean_r <= '0;
      scale_r <= OneQ16;
    end else if (cmd.clr) begin
      wsum_r <= '0;
      wtot_r <= '0;
      dev_r <= '0;
      mean_r <= '0;
      scale_r <= OneQ16;
    end else begin
      if (cmd.load) begin
        wsum_r <= wsum_r + 64'(signed'(in_value)) * signed'({48'd0, in_weight});
        wtot_r <= wtot_r + 23'(in_weight);
      end
      if (cmd.dev_acc) dev_r <= dev_r + 64'(aw);
      // a zero deviation sum (constant column) keeps scale at 1.0
      if (!div_busy && busy_d_r) begin
        if (!cmd.div_scale)
          mean_r <= mean_neg ? -quo[31:0] : quo[31:0];
        else if (dev_r != 64'd0)
          scale_r <= (quo[95:32] != 64'd0) ? 32'hFFFF_FFFF : quo[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (neg) res_value <= (p > 50'h0_8000_0000) ? 32'h8000_0000 : -p[31:0];
      else res_value <= (p > 50'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : p[31:0];
      res_mean <= mean_r;
      res_scale <= scale_r;
      res_err <= sts.zero_w;
    end
  end

  `CHK_IMPL(a_load_idle, cmd.load, !cmd.emit && !cmd.dev_acc, "load during pass")
  `CHK_NEXT(a_div_busy, cmd.div_start, div_busy, "divider did not start")
  `CHK_IMPL(a_no_restart, div_busy, !cmd.div_start, "divider restarted while busy")
endmodule

### design/wmcs_ctrl.sv
// Controller: load, mean divide, deviation pass, scale divide, emit pass.
// Depends on wmcs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wmcs_ctrl import wmcs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_end,
  input  sts_t             sts,
  output cmd_t             cmd,
  output logic [AddrW-1:0] wr_addr,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_last
);
  localparam logic [2:0] S_LOAD = 3'd0, S_MDIV = 3'd1, S_MWAIT = 3'd2,
    S_DEV = 3'd3, S_SDIV = 3'd4, S_SWAIT = 3'd5, S_EMIT = 3'd6;
  logic [2:0] st_r, st_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] idx_r, idx_nxt;
  logic rdv_r, rdv_nxt;   // read data valid next cycle
  logic ov_r, ov_nxt, last_r, last_nxt;
  logic acc;
  logic [6:0] fill_r, fill_nxt;
  logic issue;

  assign in_stall = (st_r != S_LOAD);
  assign acc = in_valid && !in_stall;
  assign wr_addr = cnt_r[AddrW-1:0];
  assign out_valid = ov_r;
  assign out_last = last_r;
  // issue an emit read only when the output slot frees up
  assign issue = (st_r == S_EMIT) && (idx_r < cnt_r) && !rdv_r && (!ov_r || !out_stall);

  // sequence the column
  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    rdv_nxt = 1'b0;
    ov_nxt = ov_r && out_stall;
    last_nxt = last_r;
    fill_nxt = fill_r;
    cmd = '0;
    cmd.rd_addr = idx_r[AddrW-1:0];
    cmd.div_scale = (st_r == S_SDIV) || (st_r == S_SWAIT) || (st_r == S_DEV);
    unique case (st_r)
      S_LOAD: begin
        if (acc) begin
          if (cnt_r < CntW'(MaxRows)) begin
            cmd.load = 1'b1;
            cnt_nxt = cnt_r + CntW'(1);
          end
          if (in_end) st_nxt = S_MDIV;
        end
      end
      S_MDIV: begin
        if (sts.zero_w) begin
          idx_nxt = '0;
          st_nxt = S_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          st_nxt = S_MWAIT;
        end
      end
      S_MWAIT: begin
        if (!sts.div_busy) begin
          idx_nxt = '0;
          st_nxt = S_DEV;
        end
      end
      S_DEV: begin
        cmd.dev_acc = rdv_r;
        if (idx_r < cnt_r) begin
          idx_nxt = idx_r + CntW'(1);
          rdv_nxt = 1'b1;
        end else if (!rdv_r) begin
          st_nxt = S_SDIV;
        end
      end
      S_SDIV: begin
        cmd.div_start = 1'b1;
        st_nxt = S_SWAIT;
      end
      S_SWAIT: begin
        if (!sts.div_busy) begin
          idx_nxt = '0;
          st_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = rdv_r;
        if (rdv_r) begin
          ov_nxt = 1'b1;
          last_nxt = (idx_r == cnt_r);
        end
        if (issue) begin
          idx_nxt = idx_r + CntW'(1);
          rdv_nxt = 1'b1;
        end
        if (idx_r == cnt_r && !rdv_r && (!ov_r || !out_stall)) begin
          cmd.clr = 1'b1;
          cnt_nxt = '0;
          idx_nxt = '0;
          st_nxt = S_LOAD;
        end
      end
      default: st_nxt = S_LOAD;
    endcase
    fill_nxt = 7'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD;
      cnt_r <= '0;
      idx_r <= '0;
      rdv_r <= 1'b0;
      ov_r <= 1'b0;
      last_r <= 1'b0;
      fill_r <= '0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      rdv_r <= rdv_nxt;
      ov_r <= ov_nxt;
      last_r <= last_nxt;
      fill_r <= fill_nxt;
    end
  end

  `CHK_IMPL(a_cnt_max, 1'b1, cnt_r <= CntW'(MaxRows) && fill_r <= 7'(MaxRows), "count overflow")
  `CHK_IMPL(a_emit_room, cmd.emit, !(ov_r && out_stall), "emit onto stalled word")
  `CHK_IMPL(a_idx_bound, 1'b1, idx_r <= cnt_r || st_r == S_LOAD, "index beyond count")
endmodule
